// ===== sv/bba_pkg.sv =====
// Shared types and command/status codes for the bitmap bit allocator.
package bba_pkg;

  // Width of the bits-in-use register
  localparam int CFG_W = 11;

  // Command codes
  localparam logic [3:0] CMD_TEST     = 4'd0;
  localparam logic [3:0] CMD_SET      = 4'd1;
  localparam logic [3:0] CMD_CLEAR    = 4'd2;
  localparam logic [3:0] CMD_TOGGLE   = 4'd3;
  localparam logic [3:0] CMD_T0_SET   = 4'd4;
  localparam logic [3:0] CMD_T1_CLEAR = 4'd5;
  localparam logic [3:0] CMD_FFS_CLR  = 4'd6;
  localparam logic [3:0] CMD_FLS_CLR  = 4'd7;
  localparam logic [3:0] CMD_FFZ_SET  = 4'd8;
  localparam logic [3:0] CMD_FLZ_SET  = 4'd9;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_NONE    = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [3:0] cmd;
    logic [9:0] bit_index;
  } item_t;

  typedef struct packed {
    logic       bit_was_set;
    logic [9:0] position;
    logic [1:0] status;
  } result_t;

endpackage

// ===== sv/bba_find_unit.sv =====
// Find-first / find-last set bit of one bitmap word.
module bba_find_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic                         from_top_i,
  output logic                         found_o,
  output logic [$clog2(WORD_BITS)-1:0] index_o
);
  import bba_pkg::*;

  localparam int BI = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] rev;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] iso;
  logic [BI-1:0]        enc;

  // Bit-reverse so that the highest set bit becomes the lowest
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      rev[b] = word_i[WORD_BITS-1-b];
    end
  end

  // Isolate lowest set bit (x & -x)
  assign sel = from_top_i ? rev : word_i;
  assign iso = sel & (~sel + WORD_BITS'(1));

  // One-hot to binary
  always_comb begin
    enc = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      enc = enc | (iso[b] ? BI'(b) : '0);
    end
  end

  assign found_o = |word_i;
  assign index_o = from_top_i ? (BI'(WORD_BITS - 1) - enc) : enc;

endmodule

// ===== sv/bitmap_bit_allocator_unit.sv =====
// Top level: bitmap bit allocator with word-serial scan sequencer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  command  | start / busy               | item_i   (cmd, bit_index)
//  result   | done_o strobe, one cycle   | result_o (bit_was_set, position, status)
//  config   | cfg_valid_i / cfg_ready_o  | cfg_data_i (bits_in_use)
//
// An accepted command that fails its range check or is an undefined code
// completes without a scan; otherwise the sequencer reads one bitmap word
// per cycle through the single memory read port and checks it in the next
// cycle in the shared word finder.
// busy is high from the cycle after a scanning command is accepted until the result strobe.
// cfg_ready_o is high only while idle with no command being taken.
// Reset clears the per-word valid bits, so the bitmap reads as all zeros
// with no clearing pass; bits_in_use resets to 1024.
// The receiver cannot stall; done_o pulses for exactly one cycle.
module bitmap_bit_allocator_unit #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bba_pkg::item_t           item_i,
  output logic                     done_o,
  output bba_pkg::result_t         result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0] cfg_data_i
);
  import bba_pkg::*;

  localparam int TOTAL_BITS = WORD_BITS * MAP_WORDS;
  localparam int BW         = $clog2(TOTAL_BITS + 1);
  localparam int CW         = ((BW > CFG_W) ? BW : CFG_W) + 1;
  localparam int BI         = $clog2(WORD_BITS);
  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W      = $clog2(MAP_WORDS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam logic [CW-1:0] TOP_BASE  = CW'((MAP_WORDS - 1) * WORD_BITS);

  // Storage
  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 dwv_q;

  // Control and datapath registers
  state_e           state_q, state_d;
  logic [3:0]       cmd_q, cmd_d;
  logic [9:0]       idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]    ibase_q, ibase_d;
  logic             dvld_q, dvld_d;
  logic [AW-1:0]    dptr_q, dptr_d;
  logic [CW-1:0]    dbase_q, dbase_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;
  logic [CFG_W-1:0] bits_q;

  // Combinational helpers
  logic [CW-1:0]        n_w;
  logic                 is_addr, want_set, from_top;
  logic                 in_addr, in_top;
  logic                 issue;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] word_w;
  logic [CW-1:0]        off;
  logic                 hit_a;
  logic [BI-1:0]        bsel;
  logic                 old_bit;
  logic [CW-1:0]        rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic                 f_found;
  logic [BI-1:0]        f_idx;
  logic [CW-1:0]        pos_full;
  logic                 last_word;
  logic                 fin;
  logic                 mem_we;
  logic [BI-1:0]        wbit;
  logic                 wval;
  logic [WORD_BITS-1:0] wdata;
  logic                 refused;

  // Effective number of bits in use, saturated to capacity
  assign n_w = (CW'(bits_q) > CW'(TOTAL_BITS)) ? CW'(TOTAL_BITS) : CW'(bits_q);

  // Command decode for the held and the incoming transaction
  assign is_addr  = (cmd_q <= CMD_T1_CLEAR);
  assign want_set = (cmd_q == CMD_FFS_CLR) || (cmd_q == CMD_FLS_CLR);
  assign from_top = (cmd_q == CMD_FLS_CLR) || (cmd_q == CMD_FLZ_SET);
  assign in_addr  = (item_i.cmd <= CMD_T1_CLEAR);
  assign in_top   = (item_i.cmd == CMD_FLS_CLR) || (item_i.cmd == CMD_FLZ_SET);

  // Read address: upward from word 0, or downward from the top word
  assign raddr = from_top ? (LAST_ADDR - cnt_q[AW-1:0]) : cnt_q[AW-1:0];

  // Examine stage: word read last cycle, unwritten words read as zero
  assign word_w = dwv_q ? rdata_q : '0;

  // Addressed bit: offset of bit_index within the examined word
  assign off     = CW'(idx_q) - dbase_q;
  assign hit_a   = !off[CW-1] && (off < CW'(WORD_BITS));
  assign bsel    = off[BI-1:0];
  assign old_bit = word_w[bsel];

  // Search: mask off bits at or beyond the bits in use
  assign rem = n_w - dbase_q;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = !rem[CW-1] && (rem > CW'(b));
    end
  end
  assign cand = (want_set ? word_w : ~word_w) & mask;

  bba_find_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .word_i     (cand),
    .from_top_i (from_top),
    .found_o    (f_found),
    .index_o    (f_idx)
  );

  assign pos_full  = dbase_q + CW'(f_idx);
  assign last_word = (cnt_q == CNT_W'(MAP_WORDS));

  // Modify decision for the examined word
  always_comb begin
    fin     = 1'b0;
    mem_we  = 1'b0;
    refused = 1'b0;
    wbit    = bsel;
    wval    = 1'b0;
    if (state_q == ST_SCAN && dvld_q) begin
      if (is_addr) begin
        fin = hit_a || last_word;
        case (cmd_q)
          CMD_SET:      wval = 1'b1;
          CMD_CLEAR:    wval = 1'b0;
          CMD_TOGGLE:   wval = !old_bit;
          CMD_T0_SET: begin
            wval    = 1'b1;
            refused = old_bit;
          end
          CMD_T1_CLEAR: begin
            wval    = 1'b0;
            refused = !old_bit;
          end
          default:      wval = old_bit;
        endcase
        mem_we = hit_a && (cmd_q != CMD_TEST) && !refused;
      end else begin
        fin    = f_found || last_word;
        wbit   = f_idx;
        wval   = !want_set;
        mem_we = f_found;
      end
    end
  end

  always_comb begin
    wdata       = word_w;
    wdata[wbit] = wval;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    ibase_d = ibase_q;
    dvld_d  = 1'b0;
    dptr_d  = dptr_q;
    dbase_d = dbase_q;
    done_d  = 1'b0;
    res_d   = res_q;
    issue   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d   = item_i.cmd;
          idx_d   = item_i.bit_index;
          cnt_d   = '0;
          ibase_d = in_top ? TOP_BASE : '0;
          res_d   = '{bit_was_set: 1'b0, position: '0, status: STAT_OK};
          if (item_i.cmd > CMD_FLZ_SET) begin
            // undefined code: no effect
            done_d = 1'b1;
          end else if (in_addr && (CW'(item_i.bit_index) >= n_w)) begin
            done_d       = 1'b1;
            res_d.status = STAT_RANGE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fin) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          res_d   = '{bit_was_set: 1'b0, position: '0, status: STAT_OK};
          if (is_addr) begin
            res_d.bit_was_set = old_bit;
            if (refused) begin
              res_d.status = STAT_REFUSED;
            end
          end else if (f_found) begin
            res_d.position = pos_full[9:0];
          end else begin
            res_d.status = STAT_NONE;
          end
        end else if (!last_word) begin
          issue   = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          ibase_d = from_top ? (ibase_q - CW'(WORD_BITS)) : (ibase_q + CW'(WORD_BITS));
          dvld_d  = 1'b1;
          dptr_d  = raddr;
          dbase_d = ibase_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dvld_q  <= 1'b0;
      done_q  <= 1'b0;
      dwv_q   <= 1'b0;
      vld_q   <= '0;
      bits_q  <= CFG_W'(1024);
    end else begin
      state_q <= state_d;
      dvld_q  <= dvld_d;
      done_q  <= done_d;
      if (issue) begin
        dwv_q <= vld_q[raddr];
      end
      if (mem_we) begin
        vld_q[dptr_q] <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        bits_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    ibase_q <= ibase_d;
    dptr_q  <= dptr_d;
    dbase_q <= dbase_d;
    res_q   <= res_d;
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[dptr_q] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Outputs; a config write never lands on the edge that takes a command
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign done_o      = done_q;
  assign result_o    = res_q;

  // Checks
  a_undef_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd > CMD_FLZ_SET) |=> done_o)
    else $error("undefined command did not complete in one cycle");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SCAN && fin))
    else $error("bitmap write outside a finishing scan cycle");

  a_range_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STAT_RANGE) |->
      (!result_o.bit_was_set && result_o.position == '0))
    else $error("out-of-range result carries data");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvld_q |-> (state_q == ST_SCAN && $past(state_q) == ST_SCAN || $past(issue)))
    else $error("examine stage valid outside a scan");

endmodule

// ===== test/bitmap_bit_allocator_unit_checker.sv =====
// Checker for the bitmap bit allocator: bitmap and bits-in-use shadow, result prediction, compare.
`timescale 1ns / 100ps

module bitmap_bit_allocator_unit_checker #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  bba_pkg::item_t            item_i,
  input  logic                      done_o,
  input  bba_pkg::result_t          result_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0] cfg_data_i,
  output int                        error_count,
  output int                        pending_count,
  output int                        results_checked,
  output int                        refused_seen,
  output int                        empty_seen,
  output int                        range_seen
);
  import bba_pkg::*;

  localparam int TOTAL_BITS = WORD_BITS * MAP_WORDS;

  typedef struct {
    item_t   item;
    result_t res;
  } alloc_expect_t;

  // Shadow copy of the block state
  logic [WORD_BITS-1:0] map_words [MAP_WORDS];
  logic [CFG_W-1:0]     bits_in_use;

  alloc_expect_t expected_allocs [$];
  alloc_expect_t oldest;

  function automatic logic map_bit(int p);
    return map_words[(p / WORD_BITS) % MAP_WORDS][p % WORD_BITS];
  endfunction

  function automatic void put_map_bit(int p, logic v);
    map_words[(p / WORD_BITS) % MAP_WORDS][p % WORD_BITS] = v;
  endfunction

  // Work out the result of one command and apply it to the shadow bitmap
  function automatic result_t predict_allocation(item_t it);
    result_t r;
    int      n;
    int      p;
    int      k;
    int      found;
    logic    old;
    logic    want_set;
    logic    from_high;
    logic    hit;
    r = '0;
    n = (bits_in_use > TOTAL_BITS) ? TOTAL_BITS : int'(bits_in_use);
    if (it.cmd <= CMD_T1_CLEAR) begin
      if (int'(it.bit_index) >= n) begin
        r.status = STAT_RANGE;
      end else begin
        old = map_bit(it.bit_index);
        r.bit_was_set = old;
        case (it.cmd)
          CMD_SET:    put_map_bit(it.bit_index, 1'b1);
          CMD_CLEAR:  put_map_bit(it.bit_index, 1'b0);
          CMD_TOGGLE: put_map_bit(it.bit_index, !old);
          CMD_T0_SET: begin
            if (old) r.status = STAT_REFUSED;
            else put_map_bit(it.bit_index, 1'b1);
          end
          CMD_T1_CLEAR: begin
            if (!old) r.status = STAT_REFUSED;
            else put_map_bit(it.bit_index, 1'b0);
          end
          default: ;
        endcase
      end
    end else if (it.cmd <= CMD_FLZ_SET) begin
      want_set  = (it.cmd == CMD_FFS_CLR) || (it.cmd == CMD_FLS_CLR);
      from_high = (it.cmd == CMD_FLS_CLR) || (it.cmd == CMD_FLZ_SET);
      hit   = 1'b0;
      found = 0;
      for (k = 0; k < n && !hit; k++) begin
        p = from_high ? (n - 1 - k) : k;
        if (map_bit(p) == want_set) begin
          hit   = 1'b1;
          found = p;
        end
      end
      if (hit) begin
        put_map_bit(found, !want_set);
        r.position = found[9:0];
      end else begin
        r.status = STAT_NONE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, item_t it, int got_v, int exp_v);
    $display("[%0t] mismatch: %s (cmd %0d index %0d): got %0d expected %0d",
             $time, what, it.cmd, it.bit_index, got_v, exp_v);
    error_count++;
  endtask

  // Observe all three channels at each clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) map_words[w] = '0;
      bits_in_use = 11'd1024;
      expected_allocs.delete();
      error_count     = 0;
      results_checked = 0;
      refused_seen    = 0;
      empty_seen      = 0;
      range_seen      = 0;
      pending_count  <= 0;
    end else begin
      // Result side first: a result never belongs to a command taken at this edge
      if (done_o) begin
        if (expected_allocs.size() == 0) begin
          report_mismatch("result with no command outstanding", item_i,
                          result_o.status, -1);
        end else begin
          oldest = expected_allocs.pop_front();
          results_checked++;
          if (result_o.bit_was_set !== oldest.res.bit_was_set)
            report_mismatch("bit_was_set", oldest.item, result_o.bit_was_set,
                            oldest.res.bit_was_set);
          if (result_o.position !== oldest.res.position)
            report_mismatch("position", oldest.item, result_o.position,
                            oldest.res.position);
          if (result_o.status !== oldest.res.status)
            report_mismatch("status", oldest.item, result_o.status, oldest.res.status);
          case (oldest.res.status)
            STAT_REFUSED: refused_seen++;
            STAT_NONE:    empty_seen++;
            STAT_RANGE:   range_seen++;
            default: ;
          endcase
        end
      end
      if (cfg_valid_i && cfg_ready_o) bits_in_use = cfg_data_i;
      if (start && !busy) begin
        oldest.item = item_i;
        oldest.res  = predict_allocation(item_i);
        expected_allocs.push_back(oldest);
      end
      pending_count <= expected_allocs.size();
    end
  end

endmodule

// ===== test/bitmap_bit_allocator_unit_test.sv =====
// Testbench top for the bitmap bit allocator: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 100ps

module bitmap_bit_allocator_unit_test;
  import bba_pkg::*;

  localparam int         WORD_BITS     = 64;
  localparam int         MAP_WORDS     = 16;
  localparam int         MAP_BITS      = WORD_BITS * MAP_WORDS;
  localparam int         SETTLE_CYCLES = MAP_WORDS + 4;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_ITEMS  = 1100;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_i;
  logic             done_o;
  result_t          result_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  int error_count;
  int pending_count;
  int results_checked;
  int refused_seen;
  int empty_seen;
  int range_seen;

  int cycle_count = 0;
  int commands_sent = 0;
  int random_sent = 0;
  int configs_written = 0;
  int bits_now = 1024;

  // Bits-in-use settings after the reset phase; the marked zero slot is drawn at random
  int plan_bits [9] = '{0, 1, 2047, 64, 65, 127, 1000, 0, 1024};
  int plan_items [9] = '{20, 40, 130, 130, 130, 130, 130, 130, 130};
  localparam int RANDOM_SLOT = 7;

  bitmap_bit_allocator_unit #(
    .WORD_BITS(WORD_BITS),
    .MAP_WORDS(MAP_WORDS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  bitmap_bit_allocator_unit_checker #(
    .WORD_BITS(WORD_BITS),
    .MAP_WORDS(MAP_WORDS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .done_o         (done_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .refused_seen   (refused_seen),
    .empty_seen     (empty_seen),
    .range_seen     (range_seen)
  );

  always #4 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sender idle ratio over the course of the random part
  function automatic int sender_idle_pct();
    if (random_sent < RANDOM_ITEMS / 3) return 25;
    if (random_sent < (2 * RANDOM_ITEMS) / 3) return 62;
    return 0;
  endfunction

  // Mostly in range, some at the in-use boundary, some anywhere
  function automatic logic [9:0] pick_index(int n);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (n > 0 && r < 70) v = $urandom_range(0, n - 1);
    else if (r < 85) v = n - 2 + int'($urandom_range(0, 3));
    else v = $urandom_range(0, MAP_BITS - 1);
    if (v < 0) v = 0;
    if (v > MAP_BITS - 1) v = MAP_BITS - 1;
    return v[9:0];
  endfunction

  function automatic logic [3:0] pick_cmd();
    if ($urandom_range(0, 99) < 4) return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    return 4'($urandom_range(CMD_TEST, CMD_FLZ_SET));
  endfunction

  // One command transaction; start stays high when no gap follows
  task automatic send_command(input logic [3:0] c, input logic [9:0] idx);
    int gap;
    int pct;
    gap = 0;
    pct = sender_idle_pct();
    while (int'($urandom_range(0, 99)) < pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_i <= '{cmd: c, bit_index: idx};
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    commands_sent++;
  endtask

  // Hold off commands until every outstanding result is back, then let the block settle
  task automatic drain(input int settle);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_bits_in_use(input int v);
    drain(SETTLE_CYCLES);
    cfg_data_i  <= v[CFG_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bits_now = (v > MAP_BITS) ? MAP_BITS : v;
    configs_written++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_command(pick_cmd(), pick_index(bits_now));
      random_sent++;
      if ($urandom_range(0, 99) == 0) drain(0);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-map searches, both ends, refusals, word edges, unused code
    send_command(CMD_FFS_CLR, 10'd0);
    send_command(CMD_FLS_CLR, 10'd0);
    send_command(CMD_FFZ_SET, 10'd0);
    send_command(CMD_FLZ_SET, 10'd0);
    send_command(CMD_TEST, 10'd0);
    send_command(CMD_TEST, 10'd1023);
    send_command(CMD_SET, 10'd512);
    send_command(CMD_T0_SET, 10'd512);
    send_command(CMD_T1_CLEAR, 10'd512);
    send_command(CMD_T1_CLEAR, 10'd512);
    send_command(CMD_T0_SET, 10'd700);
    send_command(CMD_TOGGLE, 10'd63);
    send_command(CMD_TOGGLE, 10'd64);
    send_command(CMD_TOGGLE, 10'd63);
    send_command(CMD_CLEAR, 10'd0);
    send_command(CMD_FFS_CLR, 10'd1023);
    send_command(CMD_FLS_CLR, 10'd1023);
    send_command(CMD_UNUSED_HI, 10'd1023);
    send_random(130);

    for (int ph = 0; ph < 9; ph++) begin
      write_bits_in_use((ph == RANDOM_SLOT) ? int'($urandom_range(2, 1023)) : plan_bits[ph]);
      case (plan_bits[ph])
        0: begin
          // nothing in use, except in the random slot
          send_command(CMD_TEST, 10'd0);
          send_command(CMD_FFZ_SET, 10'd0);
        end
        1: begin
          send_command(CMD_TEST, 10'd1);
          send_command(CMD_FLS_CLR, 10'd0);
        end
        2047: send_command(CMD_TEST, 10'd1023);  // saturates to the full map
        default: ;
      endcase
      send_random(plan_items[ph]);
    end

    drain(SETTLE_CYCLES);

    $display("covered %0d commands, %0d results checked, %0d bits-in-use writes", commands_sent,
             results_checked, configs_written);
    $display("including empty, single-bit and saturated maps: %0d refused, %0d not found,",
             refused_seen, empty_seen);
    $display("  %0d out of range", range_seen);
    if (error_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== bitmap_bit_allocator_unit.f =====
sv/bba_pkg.sv
sv/bba_find_unit.sv
sv/bitmap_bit_allocator_unit.sv
test/bitmap_bit_allocator_unit_checker.sv
test/bitmap_bit_allocator_unit_test.sv
